/* rtl/fzi_pkg.sv */
package fzi_pkg;

   localparam int KNEE_W = 12;
   localparam int LEVEL_W = 7;
   localparam int NUM_RULES = 9;
   localparam int SHOULDER_W = 2 * KNEE_W;
   localparam int TRIANGLE_W = 3 * KNEE_W;
   localparam int LEVELS_W = NUM_RULES * LEVEL_W;
   localparam int CSR_INDEX_W = 3;
   localparam int SCORE_W = 9;
   localparam int SCORE_MAX = 256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLD_TEMP    = 3'd0,
      CSR_NORMAL_TEMP  = 3'd1,
      CSR_HOT_TEMP     = 3'd2,
      CSR_SLOW_PULSE   = 3'd3,
      CSR_MEDIUM_PULSE = 3'd4,
      CSR_FAST_PULSE   = 3'd5,
      CSR_RULE_LEVELS  = 3'd6
   } csr_index_type;

   localparam logic [SHOULDER_W-1:0] COLD_TEMP_RESET    = 24'd1638400;
   localparam logic [TRIANGLE_W-1:0] NORMAL_TEMP_RESET  = 36'd9665446208;
   localparam logic [SHOULDER_W-1:0] HOT_TEMP_RESET     = 24'd3277360;
   localparam logic [SHOULDER_W-1:0] SLOW_PULSE_RESET   = 24'd3932160;
   localparam logic [TRIANGLE_W-1:0] MEDIUM_PULSE_RESET = 36'd27116569376;
   localparam logic [SHOULDER_W-1:0] FAST_PULSE_RESET   = 24'd7865920;
   localparam logic [LEVELS_W-1:0]   RULE_LEVELS_RESET  = 63'd2323999261970141216;

   typedef enum logic [1:0] {
      GOP_ZERO = 2'd0,
      GOP_FULL = 2'd1,
      GOP_DIV  = 2'd2
   } grade_op_type;

   // One membership evaluation: either a fixed grade or the ramp num/den.
   typedef struct packed {
      grade_op_type      op;
      logic [KNEE_W-1:0] num;
      logic [KNEE_W-1:0] den;
   } grade_req_type;

endpackage

/* rtl/two_input_fuzzy_inference.sv */
// Two-input fuzzy inference: grades a temperature and a pulse reading against
// three membership sets each, fires nine min-rules and returns the weighted
// average of the rule levels as a health score.
// Input channel: a reading is taken at each clock edge where start is high
// and busy is low. busy stays low, so a new reading may be given every cycle.
// Result channel: rsp_valid marks one beat carrying rsp_health_score and
// rsp_no_rule_fired. The receiver cannot hold results off, and none is needed:
// the block is a fixed pipeline that never stalls.
// Throughput is one reading per cycle. The pipeline runs through the input
// register, GRADE_BITS + 2 stages of the membership ramp divider, three rule
// stages, 10 stages of the weighted average divider and the output register.
// Configuration: csr_index selects a register, csr_wdata carries the value;
// csr_ready is always high. The user makes writes only while no reading is in
// flight; the block itself does not enforce this.
// Reset (synchronous, active high) empties the pipeline and reloads the
// default knees and rule levels.
module two_input_fuzzy_inference #(
   parameter int GRADE_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [fzi_pkg::KNEE_W-1:0]           req_temperature,
   input  logic [fzi_pkg::KNEE_W-1:0]           req_pulse_rate,
   output logic                                 rsp_valid,
   output logic [fzi_pkg::SCORE_W-1:0]          rsp_health_score,
   output logic                                 rsp_no_rule_fired,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fzi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fzi_pkg::LEVELS_W-1:0]         csr_wdata
);
   import fzi_pkg::*;

   localparam int G_W      = GRADE_BITS + 1;
   localparam int GDIVD_W  = KNEE_W + GRADE_BITS;
   localparam int NUM_W    = GRADE_BITS + 11;
   localparam int DEN_W    = GRADE_BITS + 4;
   localparam int FDIVD_W  = NUM_W + 2;
   localparam logic [G_W-1:0] FULL_GRADE = G_W'(1) << GRADE_BITS;

   logic [SHOULDER_W-1:0] cold_ff, hot_ff, slow_ff, fast_ff;
   logic [TRIANGLE_W-1:0] normal_ff, medium_ff;
   logic [LEVELS_W-1:0]   levels_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_ff   <= COLD_TEMP_RESET;
         normal_ff <= NORMAL_TEMP_RESET;
         hot_ff    <= HOT_TEMP_RESET;
         slow_ff   <= SLOW_PULSE_RESET;
         medium_ff <= MEDIUM_PULSE_RESET;
         fast_ff   <= FAST_PULSE_RESET;
         levels_ff <= RULE_LEVELS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLD_TEMP:    cold_ff   <= csr_wdata[SHOULDER_W-1:0];
            CSR_NORMAL_TEMP:  normal_ff <= csr_wdata[TRIANGLE_W-1:0];
            CSR_HOT_TEMP:     hot_ff    <= csr_wdata[SHOULDER_W-1:0];
            CSR_SLOW_PULSE:   slow_ff   <= csr_wdata[SHOULDER_W-1:0];
            CSR_MEDIUM_PULSE: medium_ff <= csr_wdata[TRIANGLE_W-1:0];
            CSR_FAST_PULSE:   fast_ff   <= csr_wdata[SHOULDER_W-1:0];
            CSR_RULE_LEVELS:  levels_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register.
   logic              in_vld_ff;
   logic [KNEE_W-1:0] temp_ff, pulse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff  <= req_temperature;
      pulse_ff <= req_pulse_rate;
   end

   grade_req_type [2:0] temp_req, pulse_req;
   grade_req_type [5:0] all_req;

   fzi_grade u_temp_grade (
      .x              (temp_ff),
      .falling_knees  (cold_ff),
      .triangle_knees (normal_ff),
      .rising_knees   (hot_ff),
      .grade_req      (temp_req)
   );

   fzi_grade u_pulse_grade (
      .x              (pulse_ff),
      .falling_knees  (slow_ff),
      .triangle_knees (medium_ff),
      .rising_knees   (fast_ff),
      .grade_req      (pulse_req)
   );

   assign all_req = {pulse_req, temp_req};

   logic [5:0][GDIVD_W-1:0] g_dividend;
   logic [5:0][KNEE_W-1:0]  g_divisor;
   logic [11:0]             g_ops_in, g_ops_out;
   logic [5:0][G_W-1:0]     g_quot;
   logic                    g_valid;
   logic [5:0][G_W-1:0]     grade;

   for (genvar l = 0; l < 6; l++) begin : g_lane
      assign g_dividend[l]     = {all_req[l].num, GRADE_BITS'(0)};
      assign g_divisor[l]      = all_req[l].den;
      assign g_ops_in[2*l +: 2] = all_req[l].op;

      always_comb begin
         case (grade_op_type'(g_ops_out[2*l +: 2]))
            GOP_FULL: grade[l] = FULL_GRADE;
            GOP_DIV:  grade[l] = g_quot[l];
            default:  grade[l] = '0;
         endcase
      end
   end

   fzi_divider #(
      .LANES      (6),
      .DIVIDEND_W (GDIVD_W),
      .DIVISOR_W  (KNEE_W),
      .QUOT_W     (G_W),
      .SIDE_W     (12)
   ) u_grade_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_vld_ff),
      .in_side     (g_ops_in),
      .in_dividend (g_dividend),
      .in_divisor  (g_divisor),
      .out_valid   (g_valid),
      .out_side    (g_ops_out),
      .out_quot    (g_quot)
   );

   logic             r_valid;
   logic [NUM_W-1:0] r_num;
   logic [DEN_W-1:0] r_den;

   fzi_rules #(
      .GRADE_BITS (GRADE_BITS)
   ) u_rules (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (g_valid),
      .temp_grade  (grade[2:0]),
      .pulse_grade (grade[5:3]),
      .levels      (levels_ff),
      .out_valid   (r_valid),
      .out_num     (r_num),
      .out_den     (r_den)
   );

   // Levels are in 1/64 and the score in 1/256, hence the two extra bits.
   logic [0:0][FDIVD_W-1:0] f_dividend;
   logic [0:0][DEN_W-1:0]   f_divisor;
   logic [0:0][SCORE_W-1:0] f_quot;
   logic                    f_valid, f_none;

   assign f_dividend[0] = {r_num, 2'b00};
   assign f_divisor[0]  = r_den;

   fzi_divider #(
      .LANES      (1),
      .DIVIDEND_W (FDIVD_W),
      .DIVISOR_W  (DEN_W),
      .QUOT_W     (SCORE_W),
      .SIDE_W     (1)
   ) u_score_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (r_valid),
      .in_side     (r_den == '0),
      .in_dividend (f_dividend),
      .in_divisor  (f_divisor),
      .out_valid   (f_valid),
      .out_side    (f_none),
      .out_quot    (f_quot)
   );

   logic               out_vld_ff;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               none_ff;

   always_comb begin
      if (f_none) begin
         score_in = '0;
      end else if (f_quot[0] > SCORE_W'(SCORE_MAX)) begin
         score_in = SCORE_W'(SCORE_MAX);
      end else begin
         score_in = f_quot[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      none_ff  <= f_none;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_health_score  = score_ff;
   assign rsp_no_rule_fired = none_ff;

endmodule

/* rtl/fzi_grade.sv */
module fzi_grade (
   input  logic [fzi_pkg::KNEE_W-1:0]      x,
   input  logic [fzi_pkg::SHOULDER_W-1:0]  falling_knees,
   input  logic [fzi_pkg::TRIANGLE_W-1:0]  triangle_knees,
   input  logic [fzi_pkg::SHOULDER_W-1:0]  rising_knees,
   output fzi_pkg::grade_req_type [2:0]    grade_req
);
   import fzi_pkg::*;

   logic [KNEE_W-1:0] f0, f1, ta, tb, tc, r0, r1;

   assign f0 = falling_knees[KNEE_W-1:0];
   assign f1 = falling_knees[2*KNEE_W-1:KNEE_W];
   assign ta = triangle_knees[KNEE_W-1:0];
   assign tb = triangle_knees[2*KNEE_W-1:KNEE_W];
   assign tc = triangle_knees[3*KNEE_W-1:2*KNEE_W];
   assign r0 = rising_knees[KNEE_W-1:0];
   assign r1 = rising_knees[2*KNEE_W-1:KNEE_W];

   always_comb begin
      grade_req[0] = '{op: GOP_ZERO, num: f1 - x, den: f1 - f0};
      if (x < f0) begin
         grade_req[0].op = GOP_FULL;
      end else if (x <= f1 && f1 > f0) begin
         grade_req[0].op = GOP_DIV;
      end
   end

   always_comb begin
      grade_req[1] = '{op: GOP_ZERO, num: x - ta, den: tb - ta};
      if (x < ta) begin
         grade_req[1].op = GOP_ZERO;
      end else if (x <= tb) begin
         grade_req[1].op = (tb > ta) ? GOP_DIV : GOP_FULL;
      end else if (x <= tc) begin
         grade_req[1].op = GOP_DIV;
         grade_req[1].num = tc - x;
         grade_req[1].den = tc - tb;
      end
   end

   always_comb begin
      grade_req[2] = '{op: GOP_FULL, num: x - r0, den: r1 - r0};
      if (x <= r0) begin
         grade_req[2].op = GOP_ZERO;
      end else if (x < r1) begin
         grade_req[2].op = GOP_DIV;
      end
   end

endmodule

/* rtl/fzi_divider.sv */
module fzi_divider #(
   parameter int LANES      = 1,
   parameter int DIVIDEND_W = 16,
   parameter int DIVISOR_W  = 8,
   parameter int QUOT_W     = 8,
   parameter int SIDE_W     = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [SIDE_W-1:0]                    in_side,
   input  logic [LANES-1:0][DIVIDEND_W-1:0]     in_dividend,
   input  logic [LANES-1:0][DIVISOR_W-1:0]      in_divisor,
   output logic                                 out_valid,
   output logic [SIDE_W-1:0]                    out_side,
   output logic [LANES-1:0][QUOT_W-1:0]         out_quot
);
   // The quotient is known to fit QUOT_W bits, so the upper dividend bits
   // start out as the partial remainder and one quotient bit is settled per stage.
   logic [QUOT_W:0]          vld_ff;
   logic [SIDE_W-1:0]        side_ff [QUOT_W+1];
   logic [DIVISOR_W-1:0]     rem_ff  [QUOT_W+1][LANES];
   logic [DIVISOR_W-1:0]     dvs_ff  [QUOT_W+1][LANES];
   logic [QUOT_W-1:0]        low_ff  [QUOT_W+1][LANES];
   logic [QUOT_W-1:0]        quo_ff  [QUOT_W+1][LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QUOT_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= in_side;
   end

   for (genvar l = 0; l < LANES; l++) begin : g_in
      always_ff @(posedge clock) begin
         rem_ff[0][l] <= DIVISOR_W'(in_dividend[l][DIVIDEND_W-1:QUOT_W]);
         dvs_ff[0][l] <= in_divisor[l];
         low_ff[0][l] <= in_dividend[l][QUOT_W-1:0];
         quo_ff[0][l] <= '0;
      end
   end

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      always_ff @(posedge clock) begin
         side_ff[k+1] <= side_ff[k];
      end
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DIVISOR_W:0]   trial;
         logic                 fits;
         logic [DIVISOR_W-1:0] rem_in;

         always_comb begin
            trial  = {rem_ff[k][l], low_ff[k][l][QUOT_W-1]};
            fits   = trial >= {1'b0, dvs_ff[k][l]};
            rem_in = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff[k][l]})
                          : trial[DIVISOR_W-1:0];
         end

         always_ff @(posedge clock) begin
            rem_ff[k+1][l] <= rem_in;
            dvs_ff[k+1][l] <= dvs_ff[k][l];
            low_ff[k+1][l] <= {low_ff[k][l][QUOT_W-2:0], 1'b0};
            quo_ff[k+1][l] <= {quo_ff[k][l][QUOT_W-2:0], fits};
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W];
   assign out_side  = side_ff[QUOT_W];
   for (genvar l = 0; l < LANES; l++) begin : g_out
      assign out_quot[l] = quo_ff[QUOT_W][l];
   end

endmodule

/* rtl/fzi_rules.sv */
module fzi_rules #(
   parameter int GRADE_BITS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [2:0][GRADE_BITS:0]               temp_grade,
   input  logic [2:0][GRADE_BITS:0]               pulse_grade,
   input  logic [fzi_pkg::LEVELS_W-1:0]           levels,
   output logic                                   out_valid,
   output logic [GRADE_BITS+10:0]                 out_num,
   output logic [GRADE_BITS+3:0]                  out_den
);
   import fzi_pkg::*;

   localparam int G_W    = GRADE_BITS + 1;
   localparam int PROD_W = GRADE_BITS + LEVEL_W;
   localparam int NUM_W  = GRADE_BITS + 11;
   localparam int DEN_W  = GRADE_BITS + 4;

   logic [2:0]         vld_ff;
   logic [G_W-1:0]     str_ff  [NUM_RULES];
   logic [G_W-1:0]     str_in  [NUM_RULES];
   logic [PROD_W-1:0]  prod_ff [NUM_RULES];
   logic [PROD_W-1:0]  prod_in [NUM_RULES];
   logic [DEN_W-1:0]   den_ff, den_in, den2_ff;
   logic [NUM_W-1:0]   num_ff, num_in;

   for (genvar r = 0; r < NUM_RULES; r++) begin : g_rule
      always_comb begin
         str_in[r] = (temp_grade[r/3] < pulse_grade[r%3]) ? temp_grade[r/3]
                                                          : pulse_grade[r%3];
         prod_in[r] = PROD_W'(levels[LEVEL_W*r +: LEVEL_W]) * PROD_W'(str_ff[r]);
      end
      always_ff @(posedge clock) begin
         str_ff[r]  <= str_in[r];
         prod_ff[r] <= prod_in[r];
      end
   end

   always_comb begin
      den_in = '0;
      num_in = '0;
      for (int r = 0; r < NUM_RULES; r++) begin
         den_in = den_in + DEN_W'(str_ff[r]);
         num_in = num_in + NUM_W'(prod_ff[r]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      den2_ff <= den_ff;
      num_ff  <= num_in;
   end

   assign out_valid = vld_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den2_ff;

endmodule

/* rtl/fzi_checker.sv */
module fzi_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [fzi_pkg::KNEE_W-1:0]           req_temperature,
   input logic [fzi_pkg::KNEE_W-1:0]           req_pulse_rate,
   input logic                                 rsp_valid,
   input logic [fzi_pkg::SCORE_W-1:0]          rsp_health_score,
   input logic                                 rsp_no_rule_fired,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [fzi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input logic [fzi_pkg::LEVELS_W-1:0]         csr_wdata
);
   import fzi_pkg::*;

   // A beat with no rule fired carries a zero score.
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_rule_fired |-> rsp_health_score == '0)
      else $error("no_rule_fired beat with nonzero score");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_health_score <= SCORE_W'(SCORE_MAX))
      else $error("score above full scale");

   // Reset flushes the pipeline: no beat right after it.
   a_flush: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !busy && csr_ready)
      else $error("block refused a beat");

endmodule

bind two_input_fuzzy_inference fzi_checker u_fzi_checker (.*);
